// ----- hw/rtl/sps_pkg.sv -----
// Shared types, register indexes and coil pattern tables for the stepper phase sequencer.
package sps_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CoilW  = 4;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HALF_STEP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEENERGIZE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_INTERVAL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEAD_TIME     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TIME     = 3'd4;

  // register reset values
  localparam logic [CountW-1:0] STEP_INTERVAL_RST = 16'd500;
  localparam logic [CountW-1:0] LEAD_TIME_RST     = 16'd150;
  localparam logic [CountW-1:0] HOLD_TIME_RST     = 16'd600;

  localparam logic [CoilW-1:0] COIL_RST = 4'b1111;
  localparam logic [CoilW-1:0] COIL_OFF = 4'b0000;

  localparam logic [CoilW-1:0] FULL_TAB [0:3] = '{4'b0011, 4'b1001, 4'b1100, 4'b0110};
  localparam logic [CoilW-1:0] HALF_TAB [0:7] = '{4'b0011, 4'b0001, 4'b1001, 4'b1000,
                                                  4'b1100, 4'b0100, 4'b0110, 4'b0010};

  typedef struct packed {
    logic              half_step;
    logic              deenergize;
    logic [CountW-1:0] step_interval;
    logic [CountW-1:0] lead_time;
    logic [CountW-1:0] hold_time;
  } sps_cfg_t;

  function automatic logic [PhaseW-1:0] phase_mask(input logic half_step);
    return half_step ? 3'd7 : 3'd3;
  endfunction

  function automatic logic [CoilW-1:0] coil_pattern(input logic half_step,
                                                    input logic [PhaseW-1:0] idx);
    return half_step ? HALF_TAB[idx] : FULL_TAB[idx[1:0]];
  endfunction

endpackage

// ----- hw/rtl/sps_cfg_regs.sv -----
// Configuration register file for the stepper phase sequencer.
module sps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sps_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sps_pkg::CountW-1:0]    cfg_data,
  output sps_pkg::sps_cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_step     <= 1'b0;
      cfg.deenergize    <= 1'b0;
      cfg.step_interval <= sps_pkg::STEP_INTERVAL_RST;
      cfg.lead_time     <= sps_pkg::LEAD_TIME_RST;
      cfg.hold_time     <= sps_pkg::HOLD_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sps_pkg::CFG_HALF_STEP:     cfg.half_step     <= cfg_data[0];
        sps_pkg::CFG_DEENERGIZE:    cfg.deenergize    <= cfg_data[0];
        sps_pkg::CFG_STEP_INTERVAL: cfg.step_interval <= cfg_data;
        sps_pkg::CFG_LEAD_TIME:     cfg.lead_time     <= cfg_data;
        sps_pkg::CFG_HOLD_TIME:     cfg.hold_time     <= cfg_data;
        default: ;  // unmapped index, transfer is dropped
      endcase
    end
  end

endmodule

// ----- hw/rtl/stepper_phase_sequencer.sv -----
// Stepper phase sequencer: tick counting, phase sequencing and result register.
// A result appears in the cycle after its input transfer. Throughput: one
//   item per cycle unless stalled; the phase/counter state update is a single
//   increment, compare and table lookup between the state and result registers.
// Reset (rst, synchronous): phase 0, count 0, waiting lead time, coils all on,
//   registers at their defaults, no result pending.
module stepper_phase_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sps_pkg::CoilW-1:0]     coil_drive,
  output logic                          step_taken,
  output logic [sps_pkg::PhaseW-1:0]    phase_now,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sps_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sps_pkg::CountW-1:0]    cfg_data
);

  sps_pkg::sps_cfg_t cfg;

  logic [sps_pkg::PhaseW-1:0] phase_index, phase_index_next;
  logic [sps_pkg::CountW-1:0] tick_count, tick_count_next;
  logic                       in_hold, in_hold_next;
  logic [sps_pkg::CoilW-1:0]  coil_reg, coil_reg_next;
  logic                       stepped;

  logic [sps_pkg::PhaseW-1:0] mask;
  logic [sps_pkg::PhaseW-1:0] p_cur, p_adv;
  logic [sps_pkg::CountW-1:0] cnt_inc;
  logic                       in_xfer;

  sps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign mask    = sps_pkg::phase_mask(cfg.half_step);
  assign p_cur   = phase_index & mask;
  assign p_adv   = (phase_index + 3'd1) & mask;
  assign cnt_inc = (tick_count == {sps_pkg::CountW{1'b1}}) ? tick_count
                                                           : tick_count + 16'd1;

  always_comb begin
    phase_index_next = phase_index;
    tick_count_next  = tick_count;
    in_hold_next     = in_hold;
    coil_reg_next    = coil_reg;
    stepped          = 1'b0;
    if (tick) begin
      tick_count_next = cnt_inc;
      if (!cfg.deenergize) begin
        in_hold_next = 1'b0;
        if (cnt_inc >= cfg.step_interval) begin
          coil_reg_next    = sps_pkg::coil_pattern(cfg.half_step, p_cur);
          phase_index_next = p_adv;
          stepped          = 1'b1;
          tick_count_next  = '0;
        end
      end else if (!in_hold) begin
        if (cnt_inc >= cfg.lead_time) begin
          stepped         = 1'b1;
          tick_count_next = '0;
          if (cfg.hold_time == '0) begin
            // zero hold: the pattern is skipped, coils go off and the phase advances
            coil_reg_next    = sps_pkg::COIL_OFF;
            phase_index_next = p_adv;
            in_hold_next     = 1'b0;
          end else begin
            coil_reg_next = sps_pkg::coil_pattern(cfg.half_step, p_cur);
            in_hold_next  = 1'b1;
          end
        end
      end else begin
        if (cnt_inc >= cfg.hold_time) begin
          phase_index_next = p_adv;
          tick_count_next  = '0;
          if (cfg.lead_time == '0) begin
            // zero lead: next phase pattern is driven at once, with no switch-off
            coil_reg_next = sps_pkg::coil_pattern(cfg.half_step, p_adv);
            stepped       = 1'b1;
            in_hold_next  = 1'b1;
          end else begin
            coil_reg_next = sps_pkg::COIL_OFF;
            in_hold_next  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index <= '0;
      tick_count  <= '0;
      in_hold     <= 1'b0;
      coil_reg    <= sps_pkg::COIL_RST;
      out_valid   <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_index <= phase_index_next;
        tick_count  <= tick_count_next;
        in_hold     <= in_hold_next;
        coil_reg    <= coil_reg_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      coil_drive <= coil_reg_next;
      step_taken <= stepped;
      phase_now  <= phase_index_next & mask;
    end
  end

`ifndef SYNTH
  a_idle_no_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !tick |=> out_valid && !step_taken)
    else $error("step reported for an item without a tick");

  a_cont_clears_hold: assert property (@(posedge clk) disable iff (rst)
    in_xfer && tick && !cfg.deenergize |=> !in_hold)
    else $error("hold flag left set in continuous mode");

  a_step_restarts_count: assert property (@(posedge clk) disable iff (rst)
    in_xfer && stepped |=> tick_count == '0)
    else $error("tick counter not restarted after a step");

  a_coil_tracks_state: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> coil_drive == coil_reg)
    else $error("coil output does not match coil state");
`endif

endmodule
